/* sv/ewgd_pkg.sv */
// Shared constants for the encoder wiggle gesture detector.
package ewgd_pkg;

  localparam int RING_DEPTH_DEF = 16;

  localparam int RAW_W  = 12;
  localparam int TIME_W = 32;
  localparam int POS_W  = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int REQ_W = 5;

  localparam int FULL_TURN = 4096;
  localparam int HALF_TURN = 2048;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AMPLITUDE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_REVERSALS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW        = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATIO     = 4'd7;

  localparam logic [11:0] RST_MIN_STEP      = 12'd4;
  localparam logic [15:0] RST_MIN_AMPLITUDE = 16'd80;
  localparam logic [4:0]  RST_REQ_REVERSALS = 5'd4;
  localparam logic [15:0] RST_MIN_INTERVAL  = 16'd80;
  localparam logic [15:0] RST_MAX_INTERVAL  = 16'd700;
  localparam logic [15:0] RST_WINDOW        = 16'd2000;
  localparam logic [15:0] RST_COOLDOWN      = 16'd1500;
  localparam logic [15:0] RST_MAX_RATIO     = 16'd461;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

endpackage

/* sv/ewgd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ewgd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/encoder_wiggle_gesture_detector.sv */
// Top level of the encoder wiggle gesture detector: unwrap, reversal ring, gesture check.
//
//  channel | dir | handshake          | contents
//  s_      | in  | s_tvalid/s_tready  | raw_position, time_ms
//  m_      | out | m_tvalid/m_tready  | pressed, unwrapped_position, reversal_count
//  cfg_    | in  | cfg_valid/cfg_ready| register index, write data
//
// Every word takes the step check; a direction change adds the amplitude check, and
// a recorded reversal adds the window prune and the interval scan. Both loops walk
// the ring through its single RAM read port, one entry per read and data state.
// The input is not ready until the result sits in the output register.
// Reset is synchronous; the ring contents are not cleared, only head and count.
// A stalled output holds its word; the next input is taken meanwhile.
module encoder_wiggle_gesture_detector
  import ewgd_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  localparam int CW = $clog2(RING_DEPTH + 1),
  localparam int OUT_W = 1 + POS_W + CW,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [47:0]           s_tdata,   // raw_position[11:0], time_ms[43:12]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_TW-1:0]     m_tdata,   // pressed, unwrapped_position, reversal_count
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int HW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CMPW = (CW > REQ_W) ? CW : REQ_W;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_STEP      = 4'd1;
  localparam logic [3:0] S_AMP       = 4'd2;
  localparam logic [3:0] S_PRUNE_RD  = 4'd3;
  localparam logic [3:0] S_PRUNE_CMP = 4'd4;
  localparam logic [3:0] S_CHECK     = 4'd5;
  localparam logic [3:0] S_SCAN_RD   = 4'd6;
  localparam logic [3:0] S_SCAN_DAT  = 4'd7;
  localparam logic [3:0] S_MUL       = 4'd8;
  localparam logic [3:0] S_RATIO     = 4'd9;
  localparam logic [3:0] S_DONE      = 4'd10;

  logic [3:0] state;

  logic [11:0] min_step;
  logic [15:0] min_amplitude;
  logic [REQ_W-1:0] req_rev;
  logic [15:0] interval_lo;
  logic [15:0] interval_hi;
  logic [15:0] window;
  logic [15:0] cooldown;
  logic [15:0] max_ratio;

  logic [RAW_W-1:0]  raw;
  logic [TIME_W-1:0] now;
  logic              have_sample;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  seg;
  logic [1:0]        last_dir;
  logic [1:0]        dir_r;
  logic              ever_pressed;
  logic [TIME_W-1:0] last_press;
  logic [HW-1:0]     head;
  logic [CW-1:0]     count;
  logic [CW-1:0]     scan_j;
  logic              have_prev;
  logic              have_iv;
  logic [TIME_W-1:0] prev;
  logic [TIME_W-1:0] lo;
  logic [TIME_W-1:0] hi;
  logic [47:0]       prod;
  logic              press;

  logic              out_valid;
  logic              out_pressed;
  logic [POS_W-1:0]  out_pos;
  logic [CW-1:0]     out_count;

  logic              ram_we;
  logic [HW-1:0]     ram_waddr;
  logic [HW-1:0]     ram_raddr;
  logic [TIME_W-1:0] ram_rdata;

  logic [TIME_W-1:0] sub_a;
  logic [TIME_W-1:0] sub_b;
  logic [TIME_W-1:0] sub_y;

  logic signed [13:0] delta;
  logic [POS_W-1:0]   pos_new;
  logic [11:0]        step_mag;
  logic [1:0]         step_dir;
  logic [POS_W-1:0]   amp;
  logic               ring_full;
  logic [HW-1:0]      head_eff;
  logic [CW-1:0]      count_eff;
  logic [CMPW-1:0]    count_x;
  logic [CMPW-1:0]    req_x;
  logic [CMPW-1:0]    scan_start;

  function automatic logic [HW-1:0] ring_inc(input logic [HW-1:0] h);
    logic [HW-1:0] r;
    if (h == HW'(RING_DEPTH - 1)) r = '0;
    else r = h + HW'(1);
    return r;
  endfunction

  function automatic logic [HW-1:0] ring_addr(input logic [HW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(k);
    if (s >= (CW+1)'(RING_DEPTH)) s = s - (CW+1)'(RING_DEPTH);
    return s[HW-1:0];
  endfunction

  ewgd_ram #(
    .WIDTH(TIME_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(now),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = OUT_TW'({out_count, out_pos, out_pressed});

  // shared time/position subtractor
  always_comb begin
    unique case (state)
      S_AMP: begin
        sub_a = pos;
        sub_b = seg;
      end
      S_PRUNE_CMP: begin
        sub_a = now;
        sub_b = ram_rdata;
      end
      S_CHECK: begin
        sub_a = now;
        sub_b = last_press;
      end
      S_SCAN_DAT: begin
        sub_a = ram_rdata;
        sub_b = prev;
      end
      default: begin
        sub_a = now;
        sub_b = last_press;
      end
    endcase
  end
  assign sub_y = sub_a - sub_b;

  always_comb begin
    delta = 14'(signed'({2'b00, raw})) - 14'(signed'({2'b00, pos[RAW_W-1:0]}));
    if (delta > 14'sd2048) delta = delta - 14'(FULL_TURN);
    else if (delta < -14'sd2048) delta = delta + 14'(FULL_TURN);
  end
  assign pos_new  = pos + {{(POS_W-14){delta[13]}}, delta};
  assign step_mag = delta[13] ? 12'(-delta) : delta[11:0];
  assign step_dir = (!delta[13] && (delta != 14'sd0)) ? DIR_UP : DIR_DOWN;
  assign amp      = sub_y[POS_W-1] ? (-sub_y) : sub_y;

  assign ring_full  = (count >= CW'(RING_DEPTH));
  assign head_eff   = ring_full ? ring_inc(head) : head;
  assign count_eff  = ring_full ? CW'(RING_DEPTH - 1) : count;
  assign count_x    = CMPW'(count);
  assign req_x      = CMPW'(req_rev);
  assign scan_start = count_x - req_x;

  assign ram_waddr = ring_addr(head_eff, count_eff);
  assign ram_we    = (state == S_AMP) && (amp >= POS_W'(min_amplitude));
  assign ram_raddr = (state == S_SCAN_RD) ? ring_addr(head, scan_j) : head;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_step      <= RST_MIN_STEP;
      min_amplitude <= RST_MIN_AMPLITUDE;
      req_rev       <= RST_REQ_REVERSALS;
      interval_lo   <= RST_MIN_INTERVAL;
      interval_hi   <= RST_MAX_INTERVAL;
      window        <= RST_WINDOW;
      cooldown      <= RST_COOLDOWN;
      max_ratio     <= RST_MAX_RATIO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_STEP:      min_step      <= cfg_data[11:0];
        CFG_MIN_AMPLITUDE: min_amplitude <= cfg_data;
        CFG_REQ_REVERSALS: req_rev       <= cfg_data[REQ_W-1:0];
        CFG_MIN_INTERVAL:  interval_lo   <= cfg_data;
        CFG_MAX_INTERVAL:  interval_hi   <= cfg_data;
        CFG_WINDOW:        window        <= cfg_data;
        CFG_COOLDOWN:      cooldown      <= cfg_data;
        CFG_MAX_RATIO:     max_ratio     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      have_sample  <= 1'b0;
      pos          <= '0;
      seg          <= '0;
      last_dir     <= DIR_NONE;
      ever_pressed <= 1'b0;
      last_press   <= '0;
      head         <= '0;
      count        <= '0;
      out_valid    <= 1'b0;
      press        <= 1'b0;
    end else begin
      if (out_valid && m_tready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            raw   <= s_tdata[RAW_W-1:0];
            now   <= s_tdata[RAW_W +: TIME_W];
            press <= 1'b0;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (!have_sample) begin
            have_sample <= 1'b1;
            pos   <= POS_W'(raw);
            seg   <= POS_W'(raw);
            state <= S_DONE;
          end else begin
            pos <= pos_new;
            priority if (step_mag < min_step) begin
              state <= S_DONE;
            end else if (last_dir == DIR_NONE) begin
              last_dir <= step_dir;
              seg      <= pos_new;
              state    <= S_DONE;
            end else if (step_dir == last_dir) begin
              state <= S_DONE;
            end else begin
              dir_r <= step_dir;
              state <= S_AMP;
            end
          end
        end
        S_AMP: begin
          seg      <= pos;
          last_dir <= dir_r;
          if (ram_we) begin
            head  <= head_eff;
            count <= count_eff + CW'(1);
            state <= S_PRUNE_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_PRUNE_RD: begin
          state <= (count == '0) ? S_CHECK : S_PRUNE_CMP;
        end
        S_PRUNE_CMP: begin
          if (sub_y > TIME_W'(window)) begin
            head  <= ring_inc(head);
            count <= count - CW'(1);
            state <= S_PRUNE_RD;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          priority if (ever_pressed && (sub_y < TIME_W'(cooldown))) begin
            state <= S_DONE;
          end else if (count_x < req_x) begin
            state <= S_DONE;
          end else if (req_rev <= REQ_W'(1)) begin
            ever_pressed <= 1'b1;
            last_press   <= now;
            count        <= '0;
            press        <= 1'b1;
            state        <= S_DONE;
          end else begin
            scan_j    <= scan_start[CW-1:0];
            have_prev <= 1'b0;
            have_iv   <= 1'b0;
            state     <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_DAT;
        end
        S_SCAN_DAT: begin
          prev      <= ram_rdata;
          have_prev <= 1'b1;
          scan_j    <= scan_j + CW'(1);
          if (have_prev) begin
            have_iv <= 1'b1;
            if (!have_iv || sub_y < lo) lo <= sub_y;
            if (!have_iv || sub_y > hi) hi <= sub_y;
          end
          priority if (have_prev && ((sub_y < TIME_W'(interval_lo)) ||
                                     (sub_y > TIME_W'(interval_hi)))) begin
            state <= S_DONE;
          end else if (scan_j == count - CW'(1)) begin
            state <= S_MUL;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_MUL: begin
          prod  <= 48'(max_ratio) * 48'(lo);
          state <= S_RATIO;
        end
        S_RATIO: begin
          if ((lo != '0) && (48'({hi, 8'h00}) <= prod)) begin
            ever_pressed <= 1'b1;
            last_press   <= now;
            count        <= '0;
            press        <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid   <= 1'b1;
            out_pressed <= press;
            out_pos     <= pos;
            out_count   <= count;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(RING_DEPTH))
    else $error("ring count above depth");

  a_press_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pressed) |-> (out_count == '0))
    else $error("press word with nonzero reversal count");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_STEP))
    else $error("accepted word did not start processing");

  a_dir_code: assert property (@(posedge clk) disable iff (rst)
    last_dir != 2'b11)
    else $error("bad direction code");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Testbench for the encoder wiggle gesture detector: wiggle stimulus, predicted words, checks.
module testbench;
  import ewgd_pkg::*;

  localparam int RING = RING_DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int EXPECT_DEPTH = 64;
  localparam int DIRECTED_ROWS = 22;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 4'd15;

  typedef struct packed {
    logic             pressed;
    logic [POS_W-1:0] position;
    logic [REQ_W-1:0] held;
  } gesture_word_t;

  typedef struct packed {
    logic [RAW_W-1:0]  raw;
    logic [TIME_W-1:0] stamp;
    logic              typed;
    gesture_word_t     want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [47:0]           s_tdata;   // raw_position[11:0], time_ms[43:12]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [39:0]           m_tdata;   // pressed[0], unwrapped_position[32:1], reversal_count[37:33]
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  encoder_wiggle_gesture_detector DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // limits as the block holds them
  logic [11:0] lim_step     = RST_MIN_STEP;
  logic [15:0] lim_swing    = RST_MIN_AMPLITUDE;
  logic [4:0]  lim_count    = RST_REQ_REVERSALS;
  logic [15:0] lim_iv_lo    = RST_MIN_INTERVAL;
  logic [15:0] lim_iv_hi    = RST_MAX_INTERVAL;
  logic [15:0] lim_window   = RST_WINDOW;
  logic [15:0] lim_cooldown = RST_COOLDOWN;
  logic [15:0] lim_ratio    = RST_MAX_RATIO;

  // tracker state
  bit          seen_first = 1'b0;
  logic [31:0] track_pos = '0;
  logic [31:0] swing_origin = '0;
  logic [1:0]  heading = DIR_NONE;
  bit          pressed_once = 1'b0;
  logic [31:0] press_stamp = '0;
  logic [31:0] rev_times [RING];
  int          rev_head = 0;
  int          rev_count = 0;

  gesture_word_t pending_words [EXPECT_DEPTH];
  int            pending_wr = 0;
  int            pending_rd = 0;

  // stimulus state
  logic [11:0] enc_raw;
  logic [31:0] clock_ms;
  bit          wig_up = 1'b0;
  int          seg_left = 0;
  int          seg_step = 1;
  int          seg_dt = 0;
  int          tempo = 390;
  bit          idling = 1'b1;

  int errors = 0;
  int items_sent = 0;
  int words_checked = 0;
  int presses = 0;
  int settings = 1;
  int max_held = 0;
  int quiet = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic bit spacing_ok(input logic [31:0] now);
    logic [31:0] iv;
    logic [31:0] lo;
    logic [31:0] hi;
    bit          any;
    any = 1'b0;
    lo = '0;
    hi = '0;
    if (pressed_once && (now - press_stamp) < lim_cooldown) return 1'b0;
    if (rev_count < int'(lim_count)) return 1'b0;
    for (int k = rev_count - int'(lim_count) + 1; k < rev_count; k++) begin
      iv = rev_times[(rev_head + k) % RING] - rev_times[(rev_head + k - 1) % RING];
      if (!any || iv < lo) lo = iv;
      if (!any || iv > hi) hi = iv;
      any = 1'b1;
      if (iv < lim_iv_lo || iv > lim_iv_hi) return 1'b0;
    end
    if (!any) return 1'b1;
    if (lo == 0) return 1'b0;
    return (64'(hi) << 8) <= 64'(lim_ratio) * 64'(lo);
  endfunction

  function automatic bit register_motion(input int delta, input logic [31:0] now);
    logic [31:0] mag;
    logic [31:0] diff;
    logic [31:0] swing;
    logic [1:0]  dir;
    mag = (delta < 0) ? -delta : delta;
    if (mag < lim_step) return 1'b0;
    dir = (delta > 0) ? DIR_UP : DIR_DOWN;
    if (heading == DIR_NONE) begin
      heading = dir;
      swing_origin = track_pos;
      return 1'b0;
    end
    if (dir == heading) return 1'b0;
    diff = track_pos - swing_origin;
    swing = diff[31] ? -diff : diff;
    swing_origin = track_pos;
    heading = dir;
    if (swing < lim_swing) return 1'b0;
    if (rev_count >= RING) begin
      rev_head = (rev_head + 1) % RING;
      rev_count = RING - 1;
    end
    rev_times[(rev_head + rev_count) % RING] = now;
    rev_count++;
    while (rev_count > 0 && (now - rev_times[rev_head]) > lim_window) begin
      rev_head = (rev_head + 1) % RING;
      rev_count--;
    end
    if (!spacing_ok(now)) return 1'b0;
    pressed_once = 1'b1;
    press_stamp = now;
    rev_count = 0;
    return 1'b1;
  endfunction

  function automatic gesture_word_t track_encoder(input logic [11:0] raw,
                                                  input logic [31:0] now);
    int            delta;
    gesture_word_t word;
    word.pressed = 1'b0;
    if (!seen_first) begin
      seen_first = 1'b1;
      track_pos = 32'(raw);
      swing_origin = 32'(raw);
    end else begin
      delta = int'(raw) - int'(track_pos[RAW_W-1:0]);
      if (delta > HALF_TURN) delta -= FULL_TURN;
      else if (delta < -HALF_TURN) delta += FULL_TURN;
      track_pos = track_pos + 32'(delta);
      word.pressed = register_motion(delta, now);
    end
    word.position = track_pos;
    word.held = REQ_W'(rev_count);
    return word;
  endfunction

  function automatic stim_row_t row(input logic [11:0] raw, input logic [31:0] stamp,
                                    input logic typed, input logic pressed,
                                    input logic [31:0] position, input logic [4:0] held);
    stim_row_t r;
    r.raw = raw;
    r.stamp = stamp;
    r.typed = typed;
    r.want.pressed = pressed;
    r.want.position = position;
    r.want.held = held;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected 'h%0h, got 'h%0h", $time, name, want, got);
    end
  endtask

  task automatic send_sample(input logic [11:0] raw, input logic [31:0] stamp,
                             input bit typed, input gesture_word_t want);
    int            gap;
    gesture_word_t model_word;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, stamp, raw};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model_word = track_encoder(raw, stamp);
    pending_words[pending_wr % EXPECT_DEPTH] = typed ? want : model_word;
    pending_wr++;
    items_sent++;
    if (model_word.pressed) presses++;
    if (rev_count > max_held) max_held = rev_count;
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_wr != pending_rd) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MIN_STEP:      lim_step = value[11:0];
      CFG_MIN_AMPLITUDE: lim_swing = value;
      CFG_REQ_REVERSALS: lim_count = value[4:0];
      CFG_MIN_INTERVAL:  lim_iv_lo = value;
      CFG_MAX_INTERVAL:  lim_iv_hi = value;
      CFG_WINDOW:        lim_window = value;
      CFG_COOLDOWN:      lim_cooldown = value;
      CFG_MAX_RATIO:     lim_ratio = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_limits(input logic [15:0] step, input logic [15:0] swing,
                                input logic [15:0] count, input logic [15:0] iv_lo,
                                input logic [15:0] iv_hi, input logic [15:0] window,
                                input logic [15:0] cooldown, input logic [15:0] ratio);
    write_reg(CFG_MIN_STEP, step);
    write_reg(CFG_MIN_AMPLITUDE, swing);
    write_reg(CFG_REQ_REVERSALS, count);
    write_reg(CFG_MIN_INTERVAL, iv_lo);
    write_reg(CFG_MAX_INTERVAL, iv_hi);
    write_reg(CFG_WINDOW, window);
    write_reg(CFG_COOLDOWN, cooldown);
    write_reg(CFG_MAX_RATIO, ratio);
    settings++;
  endtask

  task automatic plan_segment();
    int base;
    wig_up = !wig_up;
    seg_left = (int'(lim_swing) + 2047) / 2048 + $urandom_range(1, 4);
    seg_step = int'(lim_swing) * int'($urandom_range(100, 140)) / 100 / seg_left + 1;
    if ($urandom_range(0, 9) == 0) seg_step = seg_step / 3;
    if (seg_step < int'(lim_step)) seg_step = int'(lim_step);
    if (seg_step > HALF_TURN) seg_step = HALF_TURN;
    if (seg_step < 1) seg_step = 1;
    base = tempo;
    if ($urandom_range(0, 11) == 0) base = $urandom_range(0, 2 * tempo + 20);
    seg_dt = int'(base + $urandom_range(0, base / 5) - base / 10) / seg_left;
  endtask

  task automatic run_wiggles(input int samples);
    int roll;
    int step;
    for (int i = 0; i < samples; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        enc_raw = 12'($urandom);
        clock_ms += ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
      end else if (roll < 12) begin
        step = (lim_step == 0) ? 0
             : $urandom_range(0, (lim_step > 2048) ? 2047 : lim_step - 1);
        enc_raw = $urandom_range(0, 1) ? (enc_raw + 12'(step)) : (enc_raw - 12'(step));
        clock_ms += $urandom_range(0, 40);
      end else begin
        if (seg_left == 0) plan_segment();
        enc_raw = wig_up ? (enc_raw + 12'(seg_step)) : (enc_raw - 12'(seg_step));
        clock_ms += seg_dt + $urandom_range(0, seg_dt / 16);
        seg_left--;
      end
      send_sample(enc_raw, clock_ms, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("[encoder_wiggle_gesture_detector] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int            stall;
    bit            held_off;
    gesture_word_t want;
    gesture_word_t got;
    m_tready = 1'b0;
    held_off = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = {m_tdata[0], m_tdata[32:1], m_tdata[37:33]};
      words_checked++;
      if (pending_wr == pending_rd) begin
        errors++;
        $display("%0t: unexpected word, expected none, got pressed=%0d position='h%0h held=%0d",
                 $time, got.pressed, got.position, got.held);
      end else begin
        want = pending_words[pending_rd % EXPECT_DEPTH];
        pending_rd++;
        check_field("pressed", 32'(want.pressed), 32'(got.pressed));
        check_field("unwrapped_position", want.position, got.position);
        check_field("reversal_count", 32'(want.held), 32'(got.held));
      end
      // hold off once long enough to back up the input
      if (!held_off && words_checked == 150) begin
        held_off = 1'b1;
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          @(negedge clk);
          m_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin
    stim_row_t   directed [DIRECTED_ROWS];
    logic [15:0] iv_lo;
    logic [15:0] iv_hi;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    directed[0]  = row(12'd4095, 32'd0, 1'b1, 1'b0, 32'd4095, 5'd0);
    directed[1]  = row(12'd0, 32'd10, 1'b1, 1'b0, 32'd4096, 5'd0);
    directed[2]  = row(12'd2048, 32'd20, 1'b1, 1'b0, 32'd6144, 5'd0);
    directed[3]  = row(12'd0, 32'd30, 1'b1, 1'b0, 32'd4096, 5'd1);
    directed[4]  = row(12'd100, 32'd230, 1'b0, 1'b0, '0, '0);
    directed[5]  = row(12'd0, 32'd430, 1'b0, 1'b0, '0, '0);
    directed[6]  = row(12'd100, 32'd630, 1'b0, 1'b0, '0, '0);
    directed[7]  = row(12'd0, 32'd700, 1'b0, 1'b0, '0, '0);
    directed[8]  = row(12'd3, 32'd710, 1'b0, 1'b0, '0, '0);
    directed[9]  = row(12'd4093, 32'd720, 1'b0, 1'b0, '0, '0);
    directed[10] = row(12'd200, 32'd720, 1'b0, 1'b0, '0, '0);
    directed[11] = row(12'd0, 32'd720, 1'b0, 1'b0, '0, '0);
    directed[12] = row(12'd300, 32'd900, 1'b0, 1'b0, '0, '0);
    directed[13] = row(12'd0, 32'd1100, 1'b0, 1'b0, '0, '0);
    directed[14] = row(12'd300, 32'd1300, 1'b0, 1'b0, '0, '0);
    directed[15] = row(12'd0, 32'd1500, 1'b0, 1'b0, '0, '0);
    directed[16] = row(12'd300, 32'd1700, 1'b0, 1'b0, '0, '0);
    directed[17] = row(12'd0, 32'hFFFF_FF00, 1'b0, 1'b0, '0, '0);
    directed[18] = row(12'd300, 32'hFFFF_FFC8, 1'b0, 1'b0, '0, '0);
    directed[19] = row(12'd0, 32'h0000_0090, 1'b0, 1'b0, '0, '0);
    directed[20] = row(12'd300, 32'h0000_0158, 1'b0, 1'b0, '0, '0);
    directed[21] = row(12'd4095, 32'h0000_0160, 1'b0, 1'b0, '0, '0);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_sample(directed[i].raw, directed[i].stamp, directed[i].typed, directed[i].want);
    enc_raw = 12'd4095;
    clock_ms = 32'h0000_0160;
    tempo = 390;
    run_wiggles(220);

    settle();
    idling = 1'b0;
    program_limits(16'hF000, 16'd0, 16'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h0001);
    tempo = 300;
    run_wiggles(130);

    settle();
    idling = 1'b1;
    program_limits(16'd1, 16'd10, 16'hFFF1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd461);
    tempo = 150;
    run_wiggles(160);

    settle();
    program_limits(16'h0800, 16'hFFFF, 16'd16, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
    tempo = 65535;
    run_wiggles(70);

    settle();
    program_limits(16'd4, 16'd40, 16'h0020, 16'd50, 16'd400, 16'd1500, 16'd600, 16'd300);
    tempo = 200;
    run_wiggles(100);

    for (int p = 0; p < 4; p++) begin
      settle();
      iv_lo = 16'($urandom_range(0, 200));
      iv_hi = 16'(iv_lo + $urandom_range(100, 1500));
      program_limits(16'($urandom_range(1, 64)), 16'($urandom_range(0, 600)),
                     16'($urandom_range(1, 8)), iv_lo, iv_hi,
                     16'($urandom_range(200, 6000)), 16'($urandom_range(0, 3000)),
                     16'($urandom_range(256, 1024)));
      tempo = $urandom_range(iv_lo, iv_hi);
      idling = ($urandom_range(0, 3) != 0);
      if (p == 1) clock_ms = 32'hFFFF_8000;
      run_wiggles(130);
    end

    settle();
    repeat (200) @(posedge clk);
    $display("checked %0d words from %0d samples under %0d register settings",
             words_checked, items_sent, settings);
    $display("%0d presses seen, reversal ring held up to %0d times", presses, max_held);
    if (errors == 0) $display("[encoder_wiggle_gesture_detector] OK");
    else $display("[encoder_wiggle_gesture_detector] ERROR");
    $finish;
  end

endmodule

/* sim.f */
sv/ewgd_pkg.sv
sv/ewgd_ram.sv
sv/encoder_wiggle_gesture_detector.sv
tb/testbench.sv
